// ----- design/bti_pkg.sv -----
package bti_pkg;

    // default table geometry
    localparam int ROWS_DEFAULT = 128;
    localparam int COLS_DEFAULT = 128;

    // 0.01 in Q8.24, added to the momentum before the column split
    localparam logic [32:0] K_OFFSET = 33'd167772;

    // fixed-point constants
    localparam logic [31:0] ONE_Q24 = 32'h0100_0000;
    localparam logic [31:0] SAT_MAX = 32'hFFFF_FFFF;
    localparam logic [7:0]  DIM_RESET = 8'd128;

    // item kinds
    localparam logic [1:0] KIND_GLUON  = 2'd0;
    localparam logic [1:0] KIND_STRUCT = 2'd1;
    localparam logic [1:0] KIND_WRITE  = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_STRENGTH = 2'd1;
    localparam logic [1:0] STATUS_MOMENTUM = 2'd2;

    // register indexes (byte address bits 3:2)
    localparam logic [1:0] REG_INV_A = 2'd0;
    localparam logic [1:0] REG_INV_K = 2'd1;
    localparam logic [1:0] REG_ROWS  = 2'd2;
    localparam logic [1:0] REG_COLS  = 2'd3;

    // configuration seen by the pipeline
    typedef struct packed {
        logic [31:0] inv_a;
        logic [31:0] inv_k;
        logic [7:0]  rows;
        logic [7:0]  cols;
    } cfg_t;

    // one input item
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] momentum;
        logic [31:0] thickness;
        logic [31:0] sat_scale;
        logic [6:0]  entry_row;
        logic [6:0]  entry_col;
        logic [31:0] entry_value;
    } item_t;

    // grid position and fractions, handed to the table stages
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] ia;
        logic [23:0] fa;
        logic [16:0] ik;
        logic [23:0] fk;
        logic [63:0] ksq;
        logic [6:0]  erow;
        logic [6:0]  ecol;
        logic [31:0] evalue;
    } idx_t;

    // interpolated value, handed to the scaling stages
    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [63:0] ksq;
        logic [31:0] r;
    } lerp_t;

endpackage

// ----- design/bti_index.sv -----
module bti_index (
    input  logic           clk,
    input  logic           rst_n,
    input  bti_pkg::cfg_t  cfg,
    input  logic           in_valid,
    output logic           in_ready,
    input  bti_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output bti_pkg::idx_t  out_idx
);

    localparam int NS = 6;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] ksq;
        logic [6:0]  erow;
        logic [6:0]  ecol;
        logic [31:0] evalue;
    } carry_t;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS-1:0] en;

    // stage registers
    carry_t        c1_reg, c2_reg, c3_reg, c4_reg, c5_reg;
    logic [31:0]   t1_reg;
    logic [63:0]   qsq1_reg;
    logic [63:0]   pklo1_reg;
    logic          kk32_1_reg;
    logic [63:0]   tplo2_reg, tphi2_reg;
    logic [16:0]   ik2_reg, ik3_reg, ik4_reg, ik5_reg;
    logic [23:0]   fk2_reg, fk3_reg, fk4_reg, fk5_reg;
    logic [55:0]   a3_reg, a4_reg;
    logic [63:0]   palo5_reg;
    logic [55:0]   pahi5_reg;
    bti_pkg::idx_t out_reg;

    // combinational stage values
    carry_t        c1_next;
    logic [32:0]   kk1_next;
    logic [63:0]   qsq1_next, pklo1_next;
    logic [63:0]   tplo2_next, tphi2_next;
    logic [64:0]   pk2_next;
    logic [95:0]   prod3_next;
    logic [59:0]   s9_next;
    logic [55:0]   a4_next;
    logic [63:0]   palo5_next;
    logic [55:0]   pahi5_next;
    logic [87:0]   pa6_next;

    // stall chain: a stage moves when it is empty or the next one moves
    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || out_ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
        v_next = {v_reg[NS-2:0], in_valid};
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];
    assign out_idx   = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_next[i];
                end
            end
        end
    end

    // stage 1: squares and momentum offset product, low part
    always_comb
    begin
        c1_next.kind   = in_item.kind;
        c1_next.ksq    = {32'd0, in_item.momentum} * {32'd0, in_item.momentum};
        c1_next.erow   = in_item.entry_row;
        c1_next.ecol   = in_item.entry_col;
        c1_next.evalue = in_item.entry_value;
        kk1_next       = {1'b0, in_item.momentum} + bti_pkg::K_OFFSET;
        qsq1_next      = {32'd0, in_item.sat_scale} * {32'd0, in_item.sat_scale};
        pklo1_next     = {32'd0, kk1_next[31:0]} * {32'd0, cfg.inv_k};
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            c1_reg     <= c1_next;
            t1_reg     <= in_item.thickness;
            qsq1_reg   <= qsq1_next;
            pklo1_reg  <= pklo1_next;
            kk32_1_reg <= kk1_next[32];
        end
    end

    // stage 2: partial products of Qs^2*T, column index and fraction
    always_comb
    begin
        tplo2_next = {32'd0, qsq1_reg[31:0]} * {32'd0, t1_reg};
        tphi2_next = {32'd0, qsq1_reg[63:32]} * {32'd0, t1_reg};
        pk2_next   = {1'b0, pklo1_reg}
                   + (kk32_1_reg ? {1'b0, cfg.inv_k, 32'd0} : 65'd0);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            c2_reg    <= c1_reg;
            tplo2_reg <= tplo2_next;
            tphi2_reg <= tphi2_next;
            ik2_reg   <= pk2_next[64:48];
            fk2_reg   <= pk2_next[47:24];
        end
    end

    // stage 3: sum partials, keep Q24.32 strength base
    always_comb
    begin
        prod3_next = {32'd0, tplo2_reg} + {tphi2_reg, 32'd0};
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            c3_reg  <= c2_reg;
            a3_reg  <= prod3_next[95:40];
            ik3_reg <= ik2_reg;
            fk3_reg <= fk2_reg;
        end
    end

    // stage 4: mode factor, 9/16 or 1/4
    always_comb
    begin
        s9_next = {4'd0, a3_reg} + {1'b0, a3_reg, 3'd0};
        if (c3_reg.kind == bti_pkg::KIND_GLUON)
        begin
            a4_next = s9_next[59:4];
        end
        else
        begin
            a4_next = {2'd0, a3_reg[55:2]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            c4_reg  <= c3_reg;
            a4_reg  <= a4_next;
            ik4_reg <= ik3_reg;
            fk4_reg <= fk3_reg;
        end
    end

    // stage 5: partial products of A*inv_delta_a
    always_comb
    begin
        palo5_next = {32'd0, a4_reg[31:0]} * {32'd0, cfg.inv_a};
        pahi5_next = {32'd0, a4_reg[55:32]} * {24'd0, cfg.inv_a};
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            c5_reg    <= c4_reg;
            palo5_reg <= palo5_next;
            pahi5_reg <= pahi5_next;
            ik5_reg   <= ik4_reg;
            fk5_reg   <= fk4_reg;
        end
    end

    // stage 6: row index and fraction
    always_comb
    begin
        pa6_next = {24'd0, palo5_reg} + {pahi5_reg, 32'd0};
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            out_reg.kind   <= c5_reg.kind;
            out_reg.ia     <= pa6_next[87:56];
            out_reg.fa     <= pa6_next[55:32];
            out_reg.ik     <= ik5_reg;
            out_reg.fk     <= fk5_reg;
            out_reg.ksq    <= c5_reg.ksq;
            out_reg.erow   <= c5_reg.erow;
            out_reg.ecol   <= c5_reg.ecol;
            out_reg.evalue <= c5_reg.evalue;
        end
    end

endmodule

// ----- design/bti_table.sv -----
module bti_table #(
    parameter int ROWS = bti_pkg::ROWS_DEFAULT,
    parameter int COLS = bti_pkg::COLS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  bti_pkg::cfg_t  cfg,
    input  logic           in_valid,
    output logic           in_ready,
    input  bti_pkg::idx_t  in_idx,
    output logic           out_valid,
    input  logic           out_ready,
    output bti_pkg::lerp_t out_lerp
);

    localparam int NS   = 3;
    localparam int RW   = $clog2(ROWS);
    localparam int CW   = $clog2(COLS);
    localparam int BR   = (ROWS + 1) / 2;
    localparam int BC   = (COLS + 1) / 2;
    localparam int BD   = BR * BC;
    localparam int BA_W = (BD > 1) ? $clog2(BD) : 1;
    localparam logic [57:0] HALF_Q24 = 58'd8388608;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [23:0] fa;
        logic [23:0] fk;
        logic [63:0] ksq;
        logic        ia0;
        logic        ik0;
    } tcarry_t;

    // one bilinear step with half-up rounding: e0 + f*(e1-e0), Q.24 fraction
    function automatic logic [31:0] lerp24(input logic [23:0] f, input logic [31:0] e0,
                                           input logic [31:0] e1);
        logic signed [32:0] diff;
        logic signed [57:0] prod;
        logic [57:0]        acc;
        diff = $signed({1'b0, e1}) - $signed({1'b0, e0});
        prod = $signed({1'b0, f}) * diff;
        acc  = {2'd0, e0, 24'd0} + $unsigned(prod) + HALF_Q24;
        return acc[55:24];
    endfunction

    // address inside one parity bank
    function automatic logic [BA_W-1:0] bank_addr(input logic [31:0] rh, input logic [31:0] ch);
        logic [31:0] lin;
        lin = rh * 32'(BC) + ch;
        return lin[BA_W-1:0];
    endfunction

    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS-1:0] en;

    tcarry_t        t1_next, t1_reg, t2_reg;
    logic [31:0]    e1_reg [4];
    logic [31:0]    p0_reg, p1_reg;
    bti_pkg::lerp_t out_reg;

    logic           is_lookup;
    logic [32:0]    rmax, cmax;
    logic           fail_a, fail_k;
    logic           rd_en, wr_en;
    logic [1:0]     wbank;
    logic [BA_W-1:0] waddr;
    logic [RW-1:0]  ia_n;
    logic [CW-1:0]  ik_n;
    logic [RW:0]    rh0, rh1;
    logic [CW:0]    ch0, ch1;
    logic [31:0]    e00, e10, e01, e11;

    // stall chain
    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || out_ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
        v_next = {v_reg[NS-2:0], in_valid};
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];
    assign out_lerp  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_next[i];
                end
            end
        end
    end

    // stage 1: range check, bank addresses, table write
    always_comb
    begin
        is_lookup = (in_idx.kind == bti_pkg::KIND_GLUON) || (in_idx.kind == bti_pkg::KIND_STRUCT);
        rmax      = (33'(cfg.rows) > 33'(ROWS)) ? 33'(ROWS) : 33'(cfg.rows);
        cmax      = (33'(cfg.cols) > 33'(COLS)) ? 33'(COLS) : 33'(cfg.cols);
        fail_a    = ({1'b0, in_idx.ia} + 33'd1) >= rmax;
        fail_k    = (33'(in_idx.ik) + 33'd1) >= cmax;

        t1_next.kind = in_idx.kind;
        t1_next.fa   = in_idx.fa;
        t1_next.fk   = in_idx.fk;
        t1_next.ksq  = in_idx.ksq;
        t1_next.ia0  = in_idx.ia[0];
        t1_next.ik0  = in_idx.ik[0];
        if (!is_lookup)
        begin
            t1_next.status = bti_pkg::STATUS_OK;
        end
        else if (fail_a)
        begin
            t1_next.status = bti_pkg::STATUS_STRENGTH;
        end
        else if (fail_k)
        begin
            t1_next.status = bti_pkg::STATUS_MOMENTUM;
        end
        else
        begin
            t1_next.status = bti_pkg::STATUS_OK;
        end

        rd_en = en[0] && in_valid && is_lookup && !fail_a && !fail_k;
        wr_en = en[0] && in_valid && (in_idx.kind == bti_pkg::KIND_WRITE)
              && (32'(in_idx.erow) < 32'(ROWS)) && (32'(in_idx.ecol) < 32'(COLS));

        // even bank holds whichever of ia, ia+1 is even, odd bank the other
        ia_n = in_idx.ia[RW-1:0];
        ik_n = in_idx.ik[CW-1:0];
        rh0  = ({1'b0, ia_n} + (RW+1)'(1)) >> 1;
        rh1  = {1'b0, ia_n} >> 1;
        ch0  = ({1'b0, ik_n} + (CW+1)'(1)) >> 1;
        ch1  = {1'b0, ik_n} >> 1;

        wbank = {in_idx.erow[0], in_idx.ecol[0]};
        waddr = bank_addr(32'(in_idx.erow[6:1]), 32'(in_idx.ecol[6:1]));
    end

    // four parity banks: one write and one read per cycle each
    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        localparam logic [1:0] BANK = 2'(b);
        logic [31:0]     bank_mem [BD];
        logic [BA_W-1:0] raddr;

        assign raddr = bank_addr(BANK[1] ? 32'(rh1) : 32'(rh0),
                                 BANK[0] ? 32'(ch1) : 32'(ch0));

        always_ff @(posedge clk)
        begin
            if (wr_en && (wbank == BANK))
            begin
                bank_mem[waddr] <= in_idx.evalue;
            end
            if (rd_en)
            begin
                e1_reg[b] <= bank_mem[raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            t1_reg <= t1_next;
        end
    end

    // stage 2: sort banks back to grid corners, interpolate along rows
    always_comb
    begin
        e00 = t1_reg.ia0 ? (t1_reg.ik0 ? e1_reg[3] : e1_reg[2])
                         : (t1_reg.ik0 ? e1_reg[1] : e1_reg[0]);
        e10 = t1_reg.ia0 ? (t1_reg.ik0 ? e1_reg[1] : e1_reg[0])
                         : (t1_reg.ik0 ? e1_reg[3] : e1_reg[2]);
        e01 = t1_reg.ia0 ? (t1_reg.ik0 ? e1_reg[2] : e1_reg[3])
                         : (t1_reg.ik0 ? e1_reg[0] : e1_reg[1]);
        e11 = t1_reg.ia0 ? (t1_reg.ik0 ? e1_reg[0] : e1_reg[1])
                         : (t1_reg.ik0 ? e1_reg[2] : e1_reg[3]);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            t2_reg <= t1_reg;
            p0_reg <= lerp24(t1_reg.fa, e00, e10);
            p1_reg <= lerp24(t1_reg.fa, e01, e11);
        end
    end

    // stage 3: interpolate along columns
    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            out_reg.kind   <= t2_reg.kind;
            out_reg.status <= t2_reg.status;
            out_reg.ksq    <= t2_reg.ksq;
            out_reg.r      <= lerp24(t2_reg.fk, p0_reg, p1_reg);
        end
    end

endmodule

// ----- design/bti_scale.sv -----
module bti_scale (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  bti_pkg::lerp_t in_lerp,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [31:0]    value,
    output logic [1:0]     status
);

    localparam int NS = 3;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS-1:0] en;

    logic [1:0]  kind1_reg, kind2_reg;
    logic [1:0]  st1_reg, st2_reg;
    logic [31:0] r1_reg, r2_reg;
    logic [63:0] mlo1_reg, mhi1_reg;
    logic [95:0] p2_reg;
    logic [31:0] value_reg;
    logic [1:0]  status_reg;

    logic [95:0] p2_next;
    logic [98:0] q5;
    logic [49:0] v50;
    logic [31:0] glu_val;
    logic [31:0] value_next;

    // stall chain
    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || out_ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
        v_next = {v_reg[NS-2:0], in_valid};
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];
    assign value     = value_reg;
    assign status    = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_next[i];
                end
            end
        end
    end

    // stage 1: partial products of k^2 * r
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            kind1_reg <= in_lerp.kind;
            st1_reg   <= in_lerp.status;
            r1_reg    <= in_lerp.r;
            mlo1_reg  <= {32'd0, in_lerp.ksq[31:0]} * {32'd0, in_lerp.r};
            mhi1_reg  <= {32'd0, in_lerp.ksq[63:32]} * {32'd0, in_lerp.r};
        end
    end

    // stage 2: full product
    assign p2_next = {32'd0, mlo1_reg} + {mhi1_reg, 32'd0};

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            kind2_reg <= kind1_reg;
            st2_reg   <= st1_reg;
            r2_reg    <= r1_reg;
            p2_reg    <= p2_next;
        end
    end

    // stage 3: times 2.5 (5 / 2^49 overall), saturate, pick by kind
    always_comb
    begin
        q5      = {3'd0, p2_reg} + {1'b0, p2_reg, 2'd0};
        v50     = q5[98:49];
        glu_val = (|v50[49:32]) ? bti_pkg::SAT_MAX : v50[31:0];
        if (st2_reg != bti_pkg::STATUS_OK)
        begin
            value_next = '0;
        end
        else
        begin
            case (kind2_reg)
                bti_pkg::KIND_GLUON:  value_next = glu_val;
                bti_pkg::KIND_STRUCT: value_next = r2_reg;
                default:              value_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            value_reg  <= value_next;
            status_reg <= st2_reg;
        end
    end

endmodule

// ----- design/bilinear_table_interpolator.sv -----
// pipeline: 6 index, 3 table, 3 scale stages between input transfer and result valid
// throughput: one item per cycle while nothing stalls; every stage has its own valid bit and moves whenever
// it is empty or the stage after it moves, so a waiting result stalls only what is behind it
// table reads use four parity banks, one read port each, so all four corners are read in the same cycle
// reset: rst_n clears all valid bits and sets the registers to their defaults;
// table contents are undefined until written
module bilinear_table_interpolator #(
    parameter int ROWS = bti_pkg::ROWS_DEFAULT,
    parameter int COLS = bti_pkg::COLS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [31:0] momentum,
    input  logic [31:0] thickness,
    input  logic [31:0] sat_scale,
    input  logic [6:0]  entry_row,
    input  logic [6:0]  entry_col,
    input  logic [31:0] entry_value,
    // output channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] value,
    output logic [1:0]  status
);

    logic [31:0]    inv_a_reg;
    logic [31:0]    inv_k_reg;
    logic [7:0]     rows_reg;
    logic [7:0]     cols_reg;
    bti_pkg::cfg_t  cfg;
    bti_pkg::item_t item;
    bti_pkg::idx_t  idx;
    bti_pkg::lerp_t lerp;
    logic           idx_valid, idx_ready;
    logic           lerp_valid, lerp_ready;

    // register writes on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_a_reg <= bti_pkg::ONE_Q24;
            inv_k_reg <= bti_pkg::ONE_Q24;
            rows_reg  <= bti_pkg::DIM_RESET;
            cols_reg  <= bti_pkg::DIM_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[3:2])
                bti_pkg::REG_INV_A: inv_a_reg <= pwdata;
                bti_pkg::REG_INV_K: inv_k_reg <= pwdata;
                bti_pkg::REG_ROWS:  rows_reg  <= pwdata[7:0];
                bti_pkg::REG_COLS:  cols_reg  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        case (paddr[3:2])
            bti_pkg::REG_INV_A: prdata = inv_a_reg;
            bti_pkg::REG_INV_K: prdata = inv_k_reg;
            bti_pkg::REG_ROWS:  prdata = {24'd0, rows_reg};
            bti_pkg::REG_COLS:  prdata = {24'd0, cols_reg};
            default:            prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    always_comb
    begin
        cfg.inv_a = inv_a_reg;
        cfg.inv_k = inv_k_reg;
        cfg.rows  = rows_reg;
        cfg.cols  = cols_reg;

        item.kind        = kind;
        item.momentum    = momentum;
        item.thickness   = thickness;
        item.sat_scale   = sat_scale;
        item.entry_row   = entry_row;
        item.entry_col   = entry_col;
        item.entry_value = entry_value;
    end

    // strength and momentum to grid position
    bti_index u_index (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (item),
        .out_valid (idx_valid),
        .out_ready (idx_ready),
        .out_idx   (idx)
    );

    // banked table and bilinear interpolation
    bti_table #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (idx_valid),
        .in_ready  (idx_ready),
        .in_idx    (idx),
        .out_valid (lerp_valid),
        .out_ready (lerp_ready),
        .out_lerp  (lerp)
    );

    // gluon k^2 scaling and output register
    bti_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lerp_valid),
        .in_ready  (lerp_ready),
        .in_lerp   (lerp),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value),
        .status    (status)
    );

endmodule

// ----- design/bti_checker.sv -----
module bti_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [3:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] value,
    input logic [1:0]  status
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value) && $stable(status))
        else $error("result changed while stalled");

    // failed lookups carry a zero value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != bti_pkg::STATUS_OK) |-> value == '0)
        else $error("nonzero value with error status");

    // with the output stage empty nothing stalls the input
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // a register write reads back on the next cycle
    a_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && (paddr[3:2] == bti_pkg::REG_INV_A))
        ##1 (psel && !pwrite && (paddr[3:2] == bti_pkg::REG_INV_A))
        |-> prdata == $past(pwdata))
        else $error("register readback mismatch");

endmodule

bind bilinear_table_interpolator bti_checker u_bti_checker (.*);
